[sv/virtually_tagged_instruction_cache_macros.svh]
// ---------------------------------------------------------------------------
// Instruction cache assertion macros
// Shared concurrent assertion forms used by the cache back end.
// ---------------------------------------------------------------------------
`ifndef VIRTUALLY_TAGGED_INSTRUCTION_CACHE_MACROS_SVH
`define VIRTUALLY_TAGGED_INSTRUCTION_CACHE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define VTIC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define VTIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/vtic_pkg.sv]
// ---------------------------------------------------------------------------
// Instruction cache package
// Shared types, codes, defaults and byte extraction helpers.
// ---------------------------------------------------------------------------
package vtic_pkg;

	localparam int LINE_SHIFT_DEF = 5;
	localparam int SET_SHIFT_DEF  = 11;
	localparam int WAYS_DEF       = 1;

	localparam logic [1:0] ACT_INV_ALL  = 2'd0;
	localparam logic [1:0] ACT_INV_LINE = 2'd1;
	localparam logic [1:0] ACT_FETCH    = 2'd2;
	localparam logic [1:0] ACT_FILL     = 2'd3;

	localparam logic [1:0] FILL_FAULT   = 2'd0;
	localparam logic [1:0] FILL_UNCACHE = 2'd1;
	localparam logic [1:0] FILL_WORD    = 2'd2;
	localparam logic [1:0] FILL_MEMERR  = 2'd3;

	localparam logic [1:0] RES_DATA    = 2'd0;
	localparam logic [1:0] RES_FAULT   = 2'd1;
	localparam logic [1:0] RES_REQUEST = 2'd2;

	localparam logic [3:0] STATUS_MISALIGNED = 4'd3;
	localparam logic [3:0] STATUS_MEMERR     = 4'd13;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
		logic [2:0]  access_size;
		logic        privileged;
		logic [1:0]  fill_kind;
		logic [3:0]  fault_code;
		logic [31:0] fill_data;
	} in_item_t;

	// Queue entry: the item plus what the front end found out about it.
	typedef struct packed {
		in_item_t item;
		logic     bad_align;
	} q_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] fetch_data;
		logic        access_allowed;
		logic [3:0]  fault_status;
		logic [31:0] request_address;
		logic        request_privileged;
	} out_item_t;

	function automatic logic [31:0] size_mask(input logic [2:0] size);
		logic [31:0] m;
		case (size)
			3'd1: m = 32'h0000_00ff;
			3'd2: m = 32'h0000_ffff;
			3'd3: m = 32'h00ff_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] extract(input logic [31:0] w, input logic [1:0] off,
			input logic [2:0] size);
		return (w >> {off, 3'b000}) & size_mask(size);
	endfunction

endpackage

[sv/vtic_if.sv]
// ---------------------------------------------------------------------------
// Instruction cache channels
// Valid/ready interfaces for the request and the result channel.
// ---------------------------------------------------------------------------
interface vtic_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] address;
	logic [2:0]  access_size;
	logic        privileged;
	logic [1:0]  fill_kind;
	logic [3:0]  fault_code;
	logic [31:0] fill_data;

	modport source (output valid, action, address, access_size, privileged, fill_kind,
		fault_code, fill_data, input ready);
	modport sink (input valid, action, address, access_size, privileged, fill_kind,
		fault_code, fill_data, output ready);
endinterface

interface vtic_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] fetch_data;
	logic        access_allowed;
	logic [3:0]  fault_status;
	logic [31:0] request_address;
	logic        request_privileged;

	modport source (output valid, result_kind, fetch_data, access_allowed, fault_status,
		request_address, request_privileged, input ready);
	modport sink (input valid, result_kind, fetch_data, access_allowed, fault_status,
		request_address, request_privileged, output ready);
endinterface

[sv/virtually_tagged_instruction_cache.sv]
// ---------------------------------------------------------------------------
// Virtually tagged instruction cache
// Set-associative, virtually indexed and tagged, round-robin replacement.
// ---------------------------------------------------------------------------
// Channel  Dir  Carries
// req      in   invalidate-all, invalidate-line, fetch or fill response
// rsp      out  fetch data, fault, or miss request (at most one per request)
//
// In the back end a fetch hit goes through queue pop, tag read and line read.
// A fetch miss and an invalidate-line go through queue pop and tag read.
// Faults and fill responses other than the last line word finish in the pop cycle.
// The last line word starts a commit, line word by line word, then a tag write.
// After reset, and after each invalidate-all, a clearing pass writes every set's
// tags and pointer, one set a cycle. req.ready is low during the pass after reset
// and whenever the two-entry queue is full. A stalled rsp holds the back end,
// not the queue.
module virtually_tagged_instruction_cache #(
	parameter int LINE_SHIFT = vtic_pkg::LINE_SHIFT_DEF,
	parameter int SET_SHIFT  = vtic_pkg::SET_SHIFT_DEF,
	parameter int WAYS       = vtic_pkg::WAYS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vtic_req_if.sink  req,
	vtic_rsp_if.source rsp
);

	logic                q_valid;
	logic                q_pop;
	logic                init_busy;
	vtic_pkg::q_item_t   q_item;
	vtic_pkg::out_item_t out_item;

	// The front end classifies each transfer and holds up to two in its queue.
	vtic_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.init_busy (init_busy),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// The back end owns all cache state and the registered result.
	vtic_back #(
		.LINE_SHIFT (LINE_SHIFT),
		.SET_SHIFT  (SET_SHIFT),
		.WAYS       (WAYS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_item  (out_item)
	);

	assign rsp.result_kind        = out_item.result_kind;
	assign rsp.fetch_data         = out_item.fetch_data;
	assign rsp.access_allowed     = out_item.access_allowed;
	assign rsp.fault_status       = out_item.fault_status;
	assign rsp.request_address    = out_item.request_address;
	assign rsp.request_privileged = out_item.request_privileged;

endmodule

[sv/vtic_front.sv]
// ---------------------------------------------------------------------------
// Instruction cache front end
// Accepts requests, checks fetch alignment and queues them for the back end.
// ---------------------------------------------------------------------------
module vtic_front (
	input  logic                 clk,
	input  logic                 arst_n,
	vtic_req_if.sink             req,
	input  logic                 init_busy,
	output logic                 q_valid,
	output vtic_pkg::q_item_t    q_item,
	input  logic                 q_pop
);

	vtic_pkg::q_item_t entry_q [2];
	logic [1:0]        cnt_q;
	logic              wr_q;
	logic              rd_q;
	vtic_pkg::q_item_t new_item;
	logic              push;

	always_comb begin
		new_item.item.action      = req.action;
		new_item.item.address     = req.address;
		new_item.item.access_size = req.access_size;
		new_item.item.privileged  = req.privileged;
		new_item.item.fill_kind   = req.fill_kind;
		new_item.item.fault_code  = req.fault_code;
		new_item.item.fill_data   = req.fill_data;
		// A fetch must be 1, 2 or 4 bytes at an offset that is a multiple of its size.
		new_item.bad_align = !(req.access_size inside {3'd1, 3'd2, 3'd4}) ||
			((req.address[2:0] & (req.access_size - 3'd1)) != 3'd0);
	end

	assign req.ready = (cnt_q != 2'd2) && !init_busy;
	assign push      = req.valid && req.ready;
	assign q_valid   = cnt_q != 2'd0;
	assign q_item    = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

[sv/vtic_back.sv]
// ---------------------------------------------------------------------------
// Instruction cache back end
// Tag, pointer and line memories, miss tracking, line fill and result register.
// ---------------------------------------------------------------------------
`include "virtually_tagged_instruction_cache_macros.svh"

module vtic_back #(
	parameter int LINE_SHIFT = vtic_pkg::LINE_SHIFT_DEF,
	parameter int SET_SHIFT  = vtic_pkg::SET_SHIFT_DEF,
	parameter int WAYS       = vtic_pkg::WAYS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  vtic_pkg::q_item_t    q_item,
	output logic                 q_pop,
	output logic                 init_busy,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vtic_pkg::out_item_t  out_item
);

	localparam int WI_W  = LINE_SHIFT - 2;
	localparam int WPL   = 1 << WI_W;
	localparam int TAG_W = 32 - LINE_SHIFT - SET_SHIFT;
	localparam int ENT_W = TAG_W + 2;
	localparam int NSETS = 1 << SET_SHIFT;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LN_W  = $clog2(NSETS * WAYS);
	localparam int DA_W  = LN_W + WI_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_LOOK, ST_DATA, ST_COMMIT, ST_TAGW
	} state_t;

	state_t               state_q;
	logic [SET_SHIFT-1:0] clr_cnt_q;
	logic                 init_q;
	vtic_pkg::q_item_t    cur_q;
	logic                 miss_pending_q;
	logic [31:0]          pend_addr_q;
	logic [2:0]           pend_size_q;
	logic                 pend_priv_q;
	logic [WAY_W-1:0]     pend_way_q;
	logic [WI_W-1:0]      fill_cnt_q;
	logic [31:0]          fill_buf_q [WPL];
	logic [WI_W-1:0]      cm_cnt_q;
	logic                 out_valid_q;
	vtic_pkg::out_item_t  out_q;

	logic [WAYS*ENT_W-1:0] tag_mem [NSETS];
	logic [WAY_W-1:0]      ptr_mem [NSETS];
	logic [31:0]           data_mem [NSETS*WAYS*WPL];
	logic [WAYS*ENT_W-1:0] tag_rd_q;
	logic [WAY_W-1:0]      ptr_rd_q;
	logic [31:0]           data_rd_q;

	logic                  tag_we, ptr_we, data_we;
	logic [SET_SHIFT-1:0]  tag_wa, tag_ra;
	logic [WAYS*ENT_W-1:0] tag_wd;
	logic [WAY_W-1:0]      ptr_wd;
	logic [DA_W-1:0]       data_wa, data_ra;
	logic                  emit;
	vtic_pkg::out_item_t   emit_item;
	logic                  out_free;
	logic [SET_SHIFT-1:0]  head_set, cur_set, pend_set;
	logic [TAG_W-1:0]      cur_tag;
	logic                  hit;
	logic [WAY_W-1:0]      hit_way;
	logic [ENT_W-1:0]      hit_ent;
	logic                  fill_last;

	function automatic logic [LN_W-1:0] line_of(input logic [SET_SHIFT-1:0] s,
			input logic [WAY_W-1:0] w);
		return LN_W'(LN_W'(s) * LN_W'(WAYS) + LN_W'(w));
	endfunction

	assign head_set  = q_item.item.address[LINE_SHIFT +: SET_SHIFT];
	assign cur_set   = cur_q.item.address[LINE_SHIFT +: SET_SHIFT];
	assign pend_set  = pend_addr_q[LINE_SHIFT +: SET_SHIFT];
	assign cur_tag   = cur_q.item.address[LINE_SHIFT + SET_SHIFT +: TAG_W];
	assign out_free  = !out_valid_q || out_ready;
	assign fill_last = fill_cnt_q == WI_W'(WPL - 1);
	assign init_busy = init_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Search from the way before the pointer backwards; the nearest match wins.
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int k = WAYS; k >= 1; k--) begin
			logic [WAY_W-1:0] cand;
			logic [ENT_W-1:0] e;
			cand = (int'(ptr_rd_q) >= k) ? WAY_W'(int'(ptr_rd_q) - k)
				: WAY_W'(int'(ptr_rd_q) + WAYS - k);
			e = tag_rd_q[int'(cand)*ENT_W +: ENT_W];
			if (e[0] && (e[ENT_W-1:2] == cur_tag)) begin
				hit     = 1'b1;
				hit_way = cand;
			end
		end
		hit_ent = tag_rd_q[int'(hit_way)*ENT_W +: ENT_W];
	end

	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_item = '0;
		tag_we    = 1'b0;
		tag_wa    = cur_set;
		tag_wd    = tag_rd_q;
		tag_ra    = (state_q == ST_IDLE) ? head_set : pend_set;
		ptr_we    = 1'b0;
		ptr_wd    = '0;
		data_we   = 1'b0;
		data_wa   = {line_of(pend_set, pend_way_q), cm_cnt_q};
		data_ra   = {line_of(cur_set, hit_way), cur_q.item.address[LINE_SHIFT-1:2]};
		case (state_q)
			ST_CLEAR: begin
				tag_we = 1'b1;
				tag_wa = clr_cnt_q;
				tag_wd = '0;
				ptr_we = 1'b1;
			end
			ST_IDLE: begin
				q_pop = q_valid && out_free;
				if (q_pop && q_item.item.action == vtic_pkg::ACT_FETCH && q_item.bad_align) begin
					emit                   = 1'b1;
					emit_item.result_kind  = vtic_pkg::RES_FAULT;
					emit_item.fault_status = vtic_pkg::STATUS_MISALIGNED;
				end
				if (q_pop && q_item.item.action == vtic_pkg::ACT_FILL && miss_pending_q) begin
					case (q_item.item.fill_kind)
						vtic_pkg::FILL_FAULT: begin
							emit                   = 1'b1;
							emit_item.result_kind  = vtic_pkg::RES_FAULT;
							emit_item.fault_status = q_item.item.fault_code;
						end
						vtic_pkg::FILL_MEMERR: begin
							emit                   = 1'b1;
							emit_item.result_kind  = vtic_pkg::RES_FAULT;
							emit_item.fault_status = vtic_pkg::STATUS_MEMERR;
						end
						vtic_pkg::FILL_UNCACHE: begin
							emit                     = 1'b1;
							emit_item.result_kind    = vtic_pkg::RES_DATA;
							emit_item.fetch_data     = q_item.item.fill_data &
								vtic_pkg::size_mask(pend_size_q);
							emit_item.access_allowed = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_LOOK: begin
				if (cur_q.item.action == vtic_pkg::ACT_INV_LINE) begin
					tag_we = 1'b1;
					for (int w = 0; w < WAYS; w++) begin
						if (tag_rd_q[w*ENT_W] && tag_rd_q[w*ENT_W + 2 +: TAG_W] == cur_tag) begin
							tag_wd[w*ENT_W +: ENT_W] = '0;
						end
					end
				end else if (!(hit && (cur_q.item.privileged || !hit_ent[1]))) begin
					emit                         = 1'b1;
					emit_item.result_kind        = vtic_pkg::RES_REQUEST;
					emit_item.request_address    = {cur_q.item.address[31:LINE_SHIFT],
						LINE_SHIFT'(0)};
					emit_item.request_privileged = cur_q.item.privileged;
					if (!hit) begin
						ptr_we = 1'b1;
						ptr_wd = (ptr_rd_q == WAY_W'(WAYS - 1)) ? '0 : ptr_rd_q + 1'b1;
					end
				end
			end
			ST_DATA: begin
				emit                     = 1'b1;
				emit_item.result_kind    = vtic_pkg::RES_DATA;
				emit_item.fetch_data     = vtic_pkg::extract(data_rd_q,
					cur_q.item.address[1:0], cur_q.item.access_size);
				emit_item.access_allowed = 1'b1;
			end
			ST_COMMIT: begin
				data_we = 1'b1;
			end
			ST_TAGW: begin
				tag_we = 1'b1;
				tag_wa = pend_set;
				for (int w = 0; w < WAYS; w++) begin
					if (WAY_W'(w) == pend_way_q) begin
						tag_wd[w*ENT_W +: ENT_W] = {pend_addr_q[LINE_SHIFT + SET_SHIFT +: TAG_W],
							pend_priv_q, 1'b1};
					end
				end
				emit                     = 1'b1;
				emit_item.result_kind    = vtic_pkg::RES_DATA;
				emit_item.fetch_data     = vtic_pkg::extract(
					fill_buf_q[pend_addr_q[LINE_SHIFT-1:2]], pend_addr_q[1:0], pend_size_q);
				emit_item.access_allowed = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		tag_rd_q <= tag_mem[tag_ra];
	end

	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[tag_wa] <= ptr_wd;
		end
		ptr_rd_q <= ptr_mem[tag_ra];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_wa] <= fill_buf_q[cm_cnt_q];
		end
		data_rd_q <= data_mem[data_ra];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (q_pop && q_item.item.action == vtic_pkg::ACT_FILL && miss_pending_q &&
				q_item.item.fill_kind == vtic_pkg::FILL_WORD) begin
			fill_buf_q[fill_cnt_q] <= q_item.item.fill_data;
		end
		if (state_q == ST_LOOK && emit) begin
			pend_addr_q <= cur_q.item.address;
			pend_size_q <= cur_q.item.access_size;
			pend_priv_q <= cur_q.item.privileged;
			pend_way_q  <= hit ? hit_way : ptr_rd_q;
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			init_q         <= 1'b1;
			miss_pending_q <= 1'b0;
			fill_cnt_q     <= '0;
			cm_cnt_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						case (q_item.item.action)
							vtic_pkg::ACT_INV_ALL: begin
								state_q   <= ST_CLEAR;
								clr_cnt_q <= '0;
							end
							vtic_pkg::ACT_INV_LINE: begin
								state_q <= ST_LOOK;
							end
							vtic_pkg::ACT_FETCH: begin
								miss_pending_q <= 1'b0;
								fill_cnt_q     <= '0;
								if (!q_item.bad_align) begin
									state_q <= ST_LOOK;
								end
							end
							default: begin
								if (miss_pending_q) begin
									if (q_item.item.fill_kind == vtic_pkg::FILL_WORD) begin
										fill_cnt_q <= fill_cnt_q + 1'b1;
										if (fill_last) begin
											state_q  <= ST_COMMIT;
											cm_cnt_q <= '0;
										end
									end else begin
										miss_pending_q <= 1'b0;
										fill_cnt_q     <= '0;
									end
								end
							end
						endcase
					end
				end
				ST_LOOK: begin
					if (cur_q.item.action == vtic_pkg::ACT_INV_LINE) begin
						state_q <= ST_IDLE;
					end else if (emit) begin
						miss_pending_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					state_q <= ST_IDLE;
				end
				ST_COMMIT: begin
					cm_cnt_q <= cm_cnt_q + 1'b1;
					if (&cm_cnt_q) begin
						state_q <= ST_TAGW;
					end
				end
				ST_TAGW: begin
					miss_pending_q <= 1'b0;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`VTIC_ASSERT(a_no_pop_in_clear, clk, arst_n, (state_q == ST_CLEAR) |-> !q_pop, "pop during tag clear")
	`VTIC_ASSERT(a_fill_needs_miss, clk, arst_n, (fill_cnt_q != '0) |-> miss_pending_q, "words buffered without a miss")
	`VTIC_ASSERT(a_emit_into_free, clk, arst_n, emit |-> out_free, "result register overwritten")
	`VTIC_ASSERT_NEXT(a_commit_to_tag, clk, arst_n, (state_q == ST_COMMIT) && (&cm_cnt_q), state_q == ST_TAGW, "commit did not end in tag write")

endmodule
